FILE: hdl/grid_word_search_four_way_unit_defines.svh
// ---------------------------------------------------------------------------
// Grid word search assertion macros
// Shared concurrent assertion shorthands for the grid word search checker.
// ---------------------------------------------------------------------------
`ifndef GRID_WORD_SEARCH_FOUR_WAY_UNIT_DEFINES_SVH
`define GRID_WORD_SEARCH_FOUR_WAY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define GWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("grid word search check failed");

// Next-cycle implication, disabled while reset is held
`define GWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("grid word search check failed");

`endif

FILE: hdl/gws_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid word search package
// Field widths, command codes and defaults shared by the grid word search.
// ---------------------------------------------------------------------------
package gws_pkg;

  // Default grid edge length
  localparam int GRID_SIZE_DEF = 8;

  // Payload field widths
  localparam int CMD_W  = 1;
  localparam int IDX_W  = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  // Position reported when nothing matches
  localparam logic signed [POS_W-1:0] NO_POS = -4'sd1;

endpackage

FILE: hdl/gws_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid word search input channel
// Valid/ready channel carrying one cell write or one pattern query.
// ---------------------------------------------------------------------------
interface gws_in_if import gws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [IDX_W-1:0]  cell_row;
  logic [IDX_W-1:0]  cell_col;
  logic [CHAR_W-1:0] cell_char;
  logic [CHAR_W-1:0] pattern_first;
  logic [CHAR_W-1:0] pattern_second;
  logic [CHAR_W-1:0] pattern_third;

  modport source (
    output valid, cmd, cell_row, cell_col, cell_char,
           pattern_first, pattern_second, pattern_third,
    input  ready
  );
  modport sink (
    input  valid, cmd, cell_row, cell_col, cell_char,
           pattern_first, pattern_second, pattern_third,
    output ready
  );
endinterface

FILE: hdl/gws_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid word search result channel
// Valid/ready channel carrying the outcome of one pattern query.
// ---------------------------------------------------------------------------
interface gws_out_if import gws_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [POS_W-1:0] match_row;
  logic signed [POS_W-1:0] match_col;

  modport source (
    output valid, found, match_row, match_col,
    input  ready
  );
  modport sink (
    input  valid, found, match_row, match_col,
    output ready
  );
endinterface

FILE: hdl/grid_word_search_four_way_unit.sv
// Cell writes are accepted while idle; writes may follow back to back.
// A query streams every grid cell out of the letter memory, one read per cycle, and
// delivers its result once the scan has passed through the read and evaluation registers;
// the next transaction is accepted only after that result is loaded into the output
// register, which waits for the previous result to be taken, so queries never overlap on the single memory read port.
// Reset clears the control state only; the letter memory holds whatever it held until written.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid word search, four directions
// Stores a byte grid and finds the last row-major position where a
// three-character pattern runs right, left, down or up.
// ---------------------------------------------------------------------------
module grid_word_search_four_way_unit import gws_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  gws_in_if.sink       in_chan,
  gws_out_if.source    out_chan
);

  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SPAN  = 2 * GRID_SIZE;
  localparam int WLEN  = 4 * GRID_SIZE + 1;
  localparam int LAST  = DEPTH + SPAN - 1;
  localparam int CW    = $clog2(LAST + 1);
  localparam int RW    = $clog2(GRID_SIZE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  state_t state_r;

  logic              in_acc;
  logic              q_start;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [CHAR_W-1:0] mem [0:DEPTH-1];
  logic [CHAR_W-1:0] rdata_r;

  logic [CHAR_W-1:0] pat0_r, pat1_r, pat2_r;
  logic [CW-1:0]     iss_r;
  logic              s1_r;
  logic [CW-1:0]     s1_idx_r;
  logic              ev_r;
  logic              ev_last_r;
  logic [RW-1:0]     ev_row_r, ev_col_r;
  logic [2:0]        win_r [0:WLEN-1];

  logic              match;
  logic              hit_r, hit_nxt;
  logic [RW-1:0]     hit_row_r, hit_row_nxt, hit_col_r, hit_col_nxt;
  logic              out_free;
  logic              load_out;

  logic                    out_valid_r;
  logic                    found_r;
  logic signed [POS_W-1:0] row_r, col_r;

  // Handshake and cell write decode
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign q_start       = in_acc && (in_chan.cmd == CMD_QUERY);
  assign wr_en   = in_acc && (in_chan.cmd == CMD_WRITE)
                   && (int'(in_chan.cell_row) < GRID_SIZE)
                   && (int'(in_chan.cell_col) < GRID_SIZE);
  assign wr_addr = AW'(int'(in_chan.cell_row) * GRID_SIZE + int'(in_chan.cell_col));
  assign rd_addr = (int'(iss_r) < DEPTH) ? iss_r[AW-1:0] : '0;

  // Letter memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_chan.cell_char;
    end
    rdata_r <= mem[rd_addr];
  end

  // Shift compare flags of the streamed cells through the window
  always_ff @(posedge clk) begin
    if (s1_r) begin
      win_r[0] <= {rdata_r == pat2_r, rdata_r == pat1_r, rdata_r == pat0_r};
      for (int i = 1; i < WLEN; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // Test the four runs around the window center
  always_comb begin
    logic right_hit, left_hit, down_hit, up_hit;
    right_hit = win_r[SPAN][0] && win_r[SPAN-1][1] && win_r[SPAN-2][2]
                && (ev_col_r <= RW'(GRID_SIZE - 3));
    left_hit  = win_r[SPAN][0] && win_r[SPAN+1][1] && win_r[SPAN+2][2]
                && (ev_col_r >= RW'(2));
    down_hit  = win_r[SPAN][0] && win_r[SPAN-GRID_SIZE][1] && win_r[0][2]
                && (ev_row_r <= RW'(GRID_SIZE - 3));
    up_hit    = win_r[SPAN][0] && win_r[SPAN+GRID_SIZE][1] && win_r[WLEN-1][2]
                && (ev_row_r >= RW'(2));
    match = right_hit || left_hit || down_hit || up_hit;
  end

  // Clear on a new query, else keep the last matching position
  always_comb begin
    hit_nxt     = hit_r;
    hit_row_nxt = hit_row_r;
    hit_col_nxt = hit_col_r;
    if (q_start) begin
      hit_nxt     = 1'b0;
      hit_row_nxt = '0;
      hit_col_nxt = '0;
    end else if (ev_r && match) begin
      hit_nxt     = 1'b1;
      hit_row_nxt = ev_row_r;
      hit_col_nxt = ev_col_r;
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign load_out = ((state_r == ST_DRAIN && ev_last_r) || state_r == ST_HOLD) && out_free;

  // Sequencer: issue reads, track positions, deliver the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= '0;
      s1_r        <= 1'b0;
      s1_idx_r    <= '0;
      ev_r        <= 1'b0;
      ev_last_r   <= 1'b0;
      ev_row_r    <= '0;
      ev_col_r    <= '0;
      hit_r       <= 1'b0;
      hit_row_r   <= '0;
      hit_col_r   <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      row_r       <= NO_POS;
      col_r       <= NO_POS;
    end else begin
      // Pipeline valids behind the memory read
      s1_r      <= (state_r == ST_SCAN);
      s1_idx_r  <= iss_r;
      ev_r      <= s1_r && (int'(s1_idx_r) >= SPAN);
      ev_last_r <= s1_r && (int'(s1_idx_r) == LAST);

      hit_r     <= hit_nxt;
      hit_row_r <= hit_row_nxt;
      hit_col_r <= hit_col_nxt;

      // Restart or advance the evaluated position in row-major order
      if (q_start) begin
        ev_row_r <= '0;
        ev_col_r <= '0;
      end else if (ev_r) begin
        if (ev_col_r == RW'(GRID_SIZE - 1)) begin
          ev_col_r <= '0;
          ev_row_r <= ev_row_r + RW'(1);
        end else begin
          ev_col_r <= ev_col_r + RW'(1);
        end
      end

      // Load a new result, or drop the old one once the transaction completes
      if (load_out) begin
        out_valid_r <= 1'b1;
        found_r     <= hit_nxt;
        row_r       <= hit_nxt ? POS_W'(hit_row_nxt) : NO_POS;
        col_r       <= hit_nxt ? POS_W'(hit_col_nxt) : NO_POS;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (q_start) begin
            pat0_r    <= in_chan.pattern_first;
            pat1_r    <= in_chan.pattern_second;
            pat2_r    <= in_chan.pattern_third;
            iss_r     <= '0;
            state_r   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          iss_r <= iss_r + CW'(1);
          if (int'(iss_r) == LAST) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (ev_last_r) begin
            state_r <= out_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.found     = found_r;
  assign out_chan.match_row = row_r;
  assign out_chan.match_col = col_r;

endmodule

FILE: hdl/gws_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid word search port checker
// Watches the channels of the grid word search and flags misbehavior.
// ---------------------------------------------------------------------------
`include "grid_word_search_four_way_unit_defines.svh"

module gws_checker import gws_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [CMD_W-1:0]        in_cmd,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_found,
  input logic signed [POS_W-1:0] out_match_row,
  input logic signed [POS_W-1:0] out_match_col
);

  logic in_acc_q, in_acc_w;

  assign in_acc_q = in_valid && in_ready && (in_cmd == CMD_QUERY);
  assign in_acc_w = in_valid && in_ready && (in_cmd == CMD_WRITE);

  // A stalled result holds its transaction
  `GWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_found) && $stable(out_match_row) && $stable(out_match_col))

  // A miss reports both coordinates as minus one
  `GWS_ASSERT_NOW(a_miss_pos, clk, rst_n, out_valid && !out_found,
    out_match_row == NO_POS && out_match_col == NO_POS)

  // A query blocks further input while it scans
  `GWS_ASSERT_NEXT(a_query_busy, clk, rst_n, in_acc_q, !in_ready)

  // A query result never shows up in the next cycle
  `GWS_ASSERT_NEXT(a_query_lat, clk, rst_n, in_acc_q && !out_valid, !out_valid)

  // A cell write produces no result
  `GWS_ASSERT_NEXT(a_write_silent, clk, rst_n, in_acc_w && !out_valid, !out_valid)

endmodule

bind grid_word_search_four_way_unit gws_checker u_gws_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_cmd        (in_chan.cmd),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_found     (out_chan.found),
  .out_match_row (out_chan.match_row),
  .out_match_col (out_chan.match_col)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid word search testbench
// Fills the letter grid, runs directed pattern queries for each run direction,
// grid edges, misses and multiple hits, then random writes and queries under
// four idle/stall phases. A local scan of the grid predicts every query result.
// ---------------------------------------------------------------------------
module tb_top;
  import gws_pkg::*;

  localparam int GRID_N      = GRID_SIZE_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 325;
  localparam int SHOW_ERRORS = 10;
  localparam logic [CHAR_W-1:0] FILL_CHAR = 8'h2E;

  // Directions of a three-cell run
  typedef enum int {DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP} run_dir_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [CHAR_W-1:0] letter;
    logic [CHAR_W-1:0] pat0;
    logic [CHAR_W-1:0] pat1;
    logic [CHAR_W-1:0] pat2;
  } grid_op_t;

  typedef struct {
    logic                    found;
    logic signed [POS_W-1:0] row;
    logic signed [POS_W-1:0] col;
  } match_t;

  logic clk;
  logic rst_n;

  gws_in_if  in_chan ();
  gws_out_if out_chan ();

  grid_word_search_four_way_unit #(.GRID_SIZE(GRID_N)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Mirror of the letter grid and pending query outcomes
  logic [CHAR_W-1:0] letters [GRID_N][GRID_N];
  match_t expected_matches [$];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int cycle_count;
  int writes_sent;
  int queries_sent;
  int hits_checked;
  int misses_checked;

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Map a run direction to its row and column step
  function automatic void dir_step(input run_dir_t dir, output int dr, output int dc);
    case (dir)
      DIR_RIGHT: begin
        dr = 0;
        dc = 1;
      end
      DIR_LEFT: begin
        dr = 0;
        dc = -1;
      end
      DIR_DOWN: begin
        dr = 1;
        dc = 0;
      end
      default: begin
        dr = -1;
        dc = 0;
      end
    endcase
  endfunction

  // Scan the grid row-major; the last position with a matching run wins
  function automatic match_t find_last_match(input logic [CHAR_W-1:0] p0,
                                             input logic [CHAR_W-1:0] p1,
                                             input logic [CHAR_W-1:0] p2);
    match_t res;
    logic [CHAR_W-1:0] pat [3];
    int dr;
    int dc;
    int rr;
    int cc;
    logic hit;
    res.found = 1'b0;
    res.row   = NO_POS;
    res.col   = NO_POS;
    pat[0] = p0;
    pat[1] = p1;
    pat[2] = p2;
    for (int r = 0; r < GRID_N; r++) begin
      for (int c = 0; c < GRID_N; c++) begin
        for (int d = 0; d < 4; d++) begin
          dir_step(run_dir_t'(d), dr, dc);
          hit = 1'b1;
          for (int k = 0; k < 3; k++) begin
            rr = r + dr * k;
            cc = c + dc * k;
            if (rr < 0 || rr >= GRID_N || cc < 0 || cc >= GRID_N) begin
              hit = 1'b0;
            end else if (letters[rr][cc] != pat[k]) begin
              hit = 1'b0;
            end
          end
          if (hit) begin
            res.found = 1'b1;
            res.row   = POS_W'(r);
            res.col   = POS_W'(c);
          end
        end
      end
    end
    return res;
  endfunction

  // Build transactions; fields that the command ignores carry noise
  function automatic grid_op_t make_write(input int r, input int c,
                                          input logic [CHAR_W-1:0] ch);
    grid_op_t op;
    op.cmd    = CMD_WRITE;
    op.row    = IDX_W'(r);
    op.col    = IDX_W'(c);
    op.letter = ch;
    op.pat0   = CHAR_W'($urandom_range(255));
    op.pat1   = CHAR_W'($urandom_range(255));
    op.pat2   = CHAR_W'($urandom_range(255));
    return op;
  endfunction

  function automatic grid_op_t make_query(input logic [CHAR_W-1:0] p0,
                                          input logic [CHAR_W-1:0] p1,
                                          input logic [CHAR_W-1:0] p2);
    grid_op_t op;
    op.cmd    = CMD_QUERY;
    op.row    = IDX_W'($urandom_range(GRID_N - 1));
    op.col    = IDX_W'($urandom_range(GRID_N - 1));
    op.letter = CHAR_W'($urandom_range(255));
    op.pat0   = p0;
    op.pat1   = p1;
    op.pat2   = p2;
    return op;
  endfunction

  // Drive one transaction, wait for acceptance, then update the mirror
  task automatic issue_grid_op(input grid_op_t op);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.cmd            <= op.cmd;
    in_chan.cell_row       <= op.row;
    in_chan.cell_col       <= op.col;
    in_chan.cell_char      <= op.letter;
    in_chan.pattern_first  <= op.pat0;
    in_chan.pattern_second <= op.pat1;
    in_chan.pattern_third  <= op.pat2;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    if (op.cmd == CMD_WRITE) begin
      letters[op.row][op.col] = op.letter;
      writes_sent++;
    end else begin
      expected_matches.push_back(find_last_match(op.pat0, op.pat1, op.pat2));
      queries_sent++;
    end
  endtask

  // Receiver stalls at random
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result transaction against the oldest pending query
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (expected_matches.size() == 0) begin
        error_count++;
        if (error_count <= SHOW_ERRORS) begin
          $display("ERROR: result with no pending query: found=%0d row=%0d col=%0d",
                   out_chan.found, out_chan.match_row, out_chan.match_col);
        end
      end else begin
        want = expected_matches.pop_front();
        if (out_chan.found !== want.found || out_chan.match_row !== want.row ||
            out_chan.match_col !== want.col) begin
          error_count++;
          if (error_count <= SHOW_ERRORS) begin
            $display("ERROR: query result exp found=%0d row=%0d col=%0d, %s",
                     want.found, want.row, want.col,
                     $sformatf("got found=%0d row=%0d col=%0d",
                               out_chan.found, out_chan.match_row, out_chan.match_col));
          end
        end
        if (want.found) begin
          hits_checked++;
        end else begin
          misses_checked++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d queries pending",
               cycle_count, expected_matches.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Write every cell so no query reads unwritten memory
  task automatic test_fill_grid();
    for (int r = 0; r < GRID_N; r++) begin
      for (int c = 0; c < GRID_N; c++) begin
        issue_grid_op(make_write(r, c, FILL_CHAR));
      end
    end
  endtask

  // Miss, and a pattern hitting everywhere so the last scan position wins
  task automatic test_miss_and_ties();
    issue_grid_op(make_query(8'h41, 8'h42, 8'h43));
    issue_grid_op(make_query(FILL_CHAR, FILL_CHAR, FILL_CHAR));
    issue_grid_op(make_query(8'h00, 8'h00, 8'h00));
  endtask

  // One horizontal and one vertical run, each queried forward and reversed, with extreme byte values
  task automatic test_four_directions();
    issue_grid_op(make_write(1, 2, 8'h43));
    issue_grid_op(make_write(1, 3, 8'h41));
    issue_grid_op(make_write(1, 4, 8'h54));
    issue_grid_op(make_query(8'h43, 8'h41, 8'h54));
    issue_grid_op(make_query(8'h54, 8'h41, 8'h43));
    issue_grid_op(make_write(3, 6, 8'h00));
    issue_grid_op(make_write(4, 6, 8'h80));
    issue_grid_op(make_write(5, 6, 8'hFF));
    issue_grid_op(make_query(8'h00, 8'h80, 8'hFF));
    issue_grid_op(make_query(8'hFF, 8'h80, 8'h00));
  endtask

  // Runs touching the last row and column, and one that would wrap a row
  task automatic test_edge_runs();
    issue_grid_op(make_write(7, 5, 8'h58));
    issue_grid_op(make_write(7, 6, 8'h59));
    issue_grid_op(make_write(7, 7, 8'h5A));
    issue_grid_op(make_query(8'h58, 8'h59, 8'h5A));
    issue_grid_op(make_query(8'h5A, 8'h59, 8'h58));
    issue_grid_op(make_write(2, 6, 8'h50));
    issue_grid_op(make_write(2, 7, 8'h51));
    issue_grid_op(make_write(3, 0, 8'h52));
    issue_grid_op(make_query(8'h50, 8'h51, 8'h52));
  endtask

  // Random writes and queries; most queries copy a run that exists in the grid
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    grid_op_t op;
    run_dir_t dir;
    logic [CHAR_W-1:0] pat [3];
    logic [CHAR_W-1:0] ch;
    int dr;
    int dc;
    int r;
    int c;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(99) < 45) begin
        // Small alphabet makes repeated and overlapping runs likely
        if ($urandom_range(99) < 70) begin
          ch = CHAR_W'(8'h41 + $urandom_range(3));
        end else begin
          ch = CHAR_W'($urandom_range(255));
        end
        op = make_write($urandom_range(GRID_N - 1), $urandom_range(GRID_N - 1), ch);
      end else if ($urandom_range(99) < 75) begin
        dir = run_dir_t'($urandom_range(3));
        dir_step(dir, dr, dc);
        r = (dr < 0) ? $urandom_range(GRID_N - 1, 2) :
            (dr > 0) ? $urandom_range(GRID_N - 3) : $urandom_range(GRID_N - 1);
        c = (dc < 0) ? $urandom_range(GRID_N - 1, 2) :
            (dc > 0) ? $urandom_range(GRID_N - 3) : $urandom_range(GRID_N - 1);
        for (int k = 0; k < 3; k++) begin
          pat[k] = letters[r + dr * k][c + dc * k];
        end
        op = make_query(pat[0], pat[1], pat[2]);
      end else if ($urandom_range(1) == 1) begin
        op = make_query(CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)),
                        CHAR_W'($urandom_range(255)));
      end else begin
        op = make_query(CHAR_W'(8'h41 + $urandom_range(3)), CHAR_W'(8'h41 + $urandom_range(3)),
                        CHAR_W'(8'h41 + $urandom_range(3)));
      end
      issue_grid_op(op);
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.cmd            = CMD_WRITE;
    in_chan.cell_row       = '0;
    in_chan.cell_col       = '0;
    in_chan.cell_char      = '0;
    in_chan.pattern_first  = '0;
    in_chan.pattern_second = '0;
    in_chan.pattern_third  = '0;
    out_chan.ready         = 1'b0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    error_count            = 0;
    cycle_count            = 0;
    writes_sent            = 0;
    queries_sent           = 0;
    hits_checked           = 0;
    misses_checked         = 0;

    // Hold reset, release on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_grid();
    test_miss_and_ties();
    test_four_directions();
    test_edge_runs();
    test_random_traffic(0, 0);
    test_random_traffic(69, 0);
    test_random_traffic(0, 69);
    test_random_traffic(13, 13);

    // Drain outstanding queries, then allow one more scan time
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (2 * GRID_N * GRID_N) @(posedge clk);

    $display("Sent %0d cell writes and %0d pattern queries over four idle/stall phases",
             writes_sent, queries_sent);
    $display("Checked %0d hits and %0d misses, %0d errors",
             hits_checked, misses_checked, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/gws_pkg.sv
hdl/gws_in_if.sv
hdl/gws_out_if.sv
hdl/grid_word_search_four_way_unit.sv
hdl/gws_checker.sv
verif/tb_top.sv
